>>> hdl/lrcs_pkg.sv
// Shared constants, register indexes and controller/datapath bundles for the lane segmenter.
`timescale 1ns / 1ps

package lrcs_pkg;

	// geometry and fixed point
	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int FRAC_BITS  = 16;

	// field widths
	localparam int ROW_W   = 11;
	localparam int COL_W   = 11;
	localparam int CH_W    = 8;
	localparam int CFG_W   = 32;
	localparam int CIDX_W  = 3;
	localparam int RW_W    = 12;
	localparam int THR_W   = 10;
	localparam int DIST_W  = 10;

	// accumulators and divider
	localparam int SUM_W   = 31;
	localparam int CNT_W   = 23;
	localparam int NUM_W   = 32;
	localparam int MEAN_MAX = 255;

	// boundary arithmetic: row (as signed) times slope
	localparam int PROD_W  = ROW_W + 1 + CFG_W;
	// the clamped right boundary is at most (width << FRAC_BITS)
	localparam int FX_W    = RW_W + FRAC_BITS + 1;
	localparam int POS_W   = FX_W + 1 - FRAC_BITS;
	localparam int HALF    = 1 << (FRAC_BITS - 1);

	// stream words
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 32;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_LEFT_SLOPE   = 3'd0;
	localparam logic [CIDX_W-1:0] REG_LEFT_OFFSET  = 3'd1;
	localparam logic [CIDX_W-1:0] REG_RIGHT_SLOPE  = 3'd2;
	localparam logic [CIDX_W-1:0] REG_RIGHT_OFFSET = 3'd3;
	localparam logic [CIDX_W-1:0] REG_REGION_WIDTH = 3'd4;
	localparam logic [CIDX_W-1:0] REG_COLOR_THR    = 3'd5;

	// color channel selects for the mean division
	localparam logic [1:0] CH_BLUE  = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_RED   = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic       take;
		logic       mul_en;
		logic       edge_en;
		logic       span_en;
		logic       test_en;
		logic       match_en;
		logic       div_start;
		logic       div_store;
		logic [1:0] div_ch;
		logic       mean_commit;
		logic       out_load;
	} lrcs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic eop;
		logic div_done;
		logic out_free;
	} lrcs_sts_t;

endpackage

>>> hdl/lane_region_color_segmenter_unit.sv
// A region pass word runs through the states MUL, EDGE, SPAN and TEST to EMIT, a match pass word through MATCH.
// A new word is accepted only in IDLE, after the previous one has been loaded into the output register.
// The last region pass word adds three 32-step divisions for the mean, one per channel.
// The output register holds a result while the next word is accepted and worked on.
// Reset (arst_n low, asynchronous) clears sums, count, mean and control; config takes defaults.
`timescale 1ns / 1ps

module lane_region_color_segmenter_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lrcs_pkg::CIDX_W-1:0]         cfg_index,
	input  logic [lrcs_pkg::CFG_W-1:0]          cfg_data,
	// pixel input
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// row[10:0], col[21:11], blue[29:22], green[37:30], red[45:38], zero[47:46]
	input  logic [lrcs_pkg::IN_TDATA_W-1:0]     s_tdata,
	// op: 0 region pass, 1 color match pass
	input  logic                                s_tuser,
	// end_of_pass
	input  logic                                s_tlast,
	// result output
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// in_mask[0], mean_blue[8:1], mean_green[16:9], mean_red[24:17], mean_valid[25],
	// zero[31:26]
	output logic [lrcs_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	lrcs_pkg::lrcs_cmd_t cmd;
	lrcs_pkg::lrcs_sts_t sts;

	assign cfg_ready = 1'b1;

	lrcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	lrcs_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

>>> hdl/lrcs_div.sv
// Restoring divider, one quotient bit per cycle, used for the per-channel mean.
`timescale 1ns / 1ps

module lrcs_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [lrcs_pkg::NUM_W-1:0]   num,
	input  logic [lrcs_pkg::CNT_W-1:0]   den,
	output logic                         done,
	output logic [lrcs_pkg::NUM_W-1:0]   quot
);

	localparam int STEP_W = $clog2(lrcs_pkg::NUM_W);

	logic [lrcs_pkg::CNT_W-1:0] rem_q;
	logic [lrcs_pkg::NUM_W-1:0] quo_q;
	logic [STEP_W-1:0]          step_q;
	logic                       busy_q;
	logic                       done_q;

	logic [lrcs_pkg::CNT_W:0]   trial;
	logic                       fits;

	// shift in the next numerator bit and try the subtract
	assign trial = {rem_q, quo_q[lrcs_pkg::NUM_W-1]};
	assign fits  = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(lrcs_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? lrcs_pkg::CNT_W'(trial - {1'b0, den})
			              : lrcs_pkg::CNT_W'(trial);
			quo_q <= {quo_q[lrcs_pkg::NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

>>> hdl/lrcs_datapath.sv
// Datapath: config registers, trapezoid test, color sums, mean, match test and output word.
`timescale 1ns / 1ps

module lrcs_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	// config writes
	input  logic                                cfg_valid,
	input  logic [lrcs_pkg::CIDX_W-1:0]         cfg_index,
	input  logic [lrcs_pkg::CFG_W-1:0]          cfg_data,
	// input word
	input  logic                                s_tuser,
	input  logic                                s_tlast,
	input  logic [lrcs_pkg::IN_TDATA_W-1:0]     s_tdata,
	// control
	input  lrcs_pkg::lrcs_cmd_t                 cmd,
	output lrcs_pkg::lrcs_sts_t                 sts,
	// output word
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [lrcs_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	localparam int PW = lrcs_pkg::PROD_W;
	localparam int XW = lrcs_pkg::FX_W;
	localparam int QW = lrcs_pkg::POS_W;

	// config registers
	logic signed [lrcs_pkg::CFG_W-1:0] left_slope_q, left_offset_q;
	logic signed [lrcs_pkg::CFG_W-1:0] right_slope_q, right_offset_q;
	logic [lrcs_pkg::RW_W-1:0]         region_width_q;
	logic [lrcs_pkg::THR_W-1:0]        color_threshold_q;

	// captured word
	logic                        op_q, eop_q;
	logic [lrcs_pkg::ROW_W-1:0]  row_q;
	logic [lrcs_pkg::COL_W-1:0]  col_q;
	logic [lrcs_pkg::CH_W-1:0]   blue_q, green_q, red_q;

	// boundary pipeline
	logic signed [PW-1:0]  prod_l_s1, prod_r_s1;
	logic signed [PW-1:0]  xl_s2, xr_s2;
	logic                  empty_s3;
	logic [QW-1:0]         start_s3, len_s3;

	// accumulators and mean
	logic [lrcs_pkg::SUM_W-1:0] sum_b_q, sum_g_q, sum_r_q;
	logic [lrcs_pkg::CNT_W-1:0] count_q;
	logic [lrcs_pkg::CH_W-1:0]  mean_b_q, mean_g_q, mean_r_q;
	logic                       mask_q;
	logic                       mv_q;

	// output register
	logic                                m_tvalid_q;
	logic [lrcs_pkg::OUT_TDATA_W-1:0]    m_tdata_q;

	// combinational helpers
	logic [lrcs_pkg::RW_W-1:0]  w_lim;
	logic signed [PW-1:0]       wlim_fx;
	logic signed [PW-1:0]       xl_raw, xr_raw, span_diff;
	logic [XW:0]                start_sum, len_sum;
	logic [QW:0]                span_end, end_clip, col_x;
	logic                       row_big, in_trap;
	logic [lrcs_pkg::DIST_W-1:0] l1_dist;
	logic [lrcs_pkg::SUM_W-1:0] sum_sel;
	logic [lrcs_pkg::NUM_W-1:0] div_num, div_quot;
	logic                       div_done;
	logic [lrcs_pkg::CH_W-1:0]  mean_val;

	function automatic logic [lrcs_pkg::CH_W-1:0] abs_diff(
		input logic [lrcs_pkg::CH_W-1:0] a,
		input logic [lrcs_pkg::CH_W-1:0] b
	);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	// config write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_slope_q      <= '0;
			left_offset_q     <= '0;
			right_slope_q     <= '0;
			right_offset_q    <= '0;
			region_width_q    <= lrcs_pkg::RW_W'(2048);
			color_threshold_q <= lrcs_pkg::THR_W'(50);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lrcs_pkg::REG_LEFT_SLOPE:   left_slope_q   <= cfg_data;
				lrcs_pkg::REG_LEFT_OFFSET:  left_offset_q  <= cfg_data;
				lrcs_pkg::REG_RIGHT_SLOPE:  right_slope_q  <= cfg_data;
				lrcs_pkg::REG_RIGHT_OFFSET: right_offset_q <= cfg_data;
				lrcs_pkg::REG_REGION_WIDTH:
					region_width_q <= cfg_data[lrcs_pkg::RW_W-1:0];
				lrcs_pkg::REG_COLOR_THR:
					color_threshold_q <= cfg_data[lrcs_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// capture the accepted word
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q    <= s_tuser;
			eop_q   <= s_tlast;
			row_q   <= s_tdata[10:0];
			col_q   <= s_tdata[21:11];
			blue_q  <= s_tdata[29:22];
			green_q <= s_tdata[37:30];
			red_q   <= s_tdata[45:38];
		end
	end

	// effective right clamp in pixels and in fixed point
	assign w_lim   = (32'(region_width_q) > lrcs_pkg::MAX_WIDTH)
	               ? lrcs_pkg::RW_W'(lrcs_pkg::MAX_WIDTH) : region_width_q;
	assign wlim_fx = $signed(PW'({w_lim, {lrcs_pkg::FRAC_BITS{1'b0}}}));

	// stage 1: row times slope
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_l_s1 <= PW'($signed({1'b0, row_q})) * PW'(left_slope_q);
			prod_r_s1 <= PW'($signed({1'b0, row_q})) * PW'(right_slope_q);
		end
	end

	// stage 2: add offsets, clamp left at 0 and right at width
	assign xl_raw = prod_l_s1 + PW'(left_offset_q);
	assign xr_raw = prod_r_s1 + PW'(right_offset_q);

	always_ff @(posedge clk) begin
		if (cmd.edge_en) begin
			xl_s2 <= xl_raw[PW-1] ? '0 : xl_raw;
			xr_s2 <= (xr_raw > wlim_fx) ? wlim_fx : xr_raw;
		end
	end

	// stage 3: empty check, rounded start and length
	assign span_diff = xr_s2 - xl_s2;
	assign start_sum = {1'b0, xl_s2[XW-1:0]} + (XW+1)'(lrcs_pkg::HALF);
	assign len_sum   = {1'b0, span_diff[XW-1:0]} + (XW+1)'(lrcs_pkg::HALF);

	always_ff @(posedge clk) begin
		if (cmd.span_en) begin
			empty_s3 <= (xr_s2 <= xl_s2);
			start_s3 <= start_sum[XW:lrcs_pkg::FRAC_BITS];
			len_s3   <= len_sum[XW:lrcs_pkg::FRAC_BITS];
		end
	end

	// stage 4: span end clamp and column test
	assign span_end = {1'b0, start_s3} + {1'b0, len_s3};
	assign end_clip = (span_end > (QW+1)'(w_lim)) ? (QW+1)'(w_lim) : span_end;
	assign col_x    = (QW+1)'(col_q);
	assign row_big  = (32'(row_q) >= lrcs_pkg::MAX_HEIGHT);
	assign in_trap  = !empty_s3 && !row_big && (col_x >= {1'b0, start_s3})
	                && (col_x < end_clip);

	// L1 distance to the latched mean
	assign l1_dist = lrcs_pkg::DIST_W'(abs_diff(blue_q, mean_b_q))
	               + lrcs_pkg::DIST_W'(abs_diff(green_q, mean_g_q))
	               + lrcs_pkg::DIST_W'(abs_diff(red_q, mean_r_q));

	// divider operand select
	always_comb begin
		case (cmd.div_ch)
			lrcs_pkg::CH_BLUE:  sum_sel = sum_b_q;
			lrcs_pkg::CH_GREEN: sum_sel = sum_g_q;
			default:            sum_sel = sum_r_q;
		endcase
	end

	assign div_num = lrcs_pkg::NUM_W'(sum_sel) + lrcs_pkg::NUM_W'(count_q >> 1);

	lrcs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (count_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// rounded mean, zero for an empty pass, saturated at full scale
	assign mean_val = (count_q == '0) ? '0
	                : (div_quot > lrcs_pkg::NUM_W'(lrcs_pkg::MEAN_MAX))
	                ? lrcs_pkg::CH_W'(lrcs_pkg::MEAN_MAX) : div_quot[lrcs_pkg::CH_W-1:0];

	// sums, count, means, mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_b_q  <= '0;
			sum_g_q  <= '0;
			sum_r_q  <= '0;
			count_q  <= '0;
			mean_b_q <= '0;
			mean_g_q <= '0;
			mean_r_q <= '0;
			mask_q   <= 1'b0;
			mv_q     <= 1'b0;
		end else begin
			if (cmd.take)
				mv_q <= 1'b0;
			if (cmd.test_en) begin
				mask_q <= in_trap;
				if (in_trap) begin
					sum_b_q <= sum_b_q + lrcs_pkg::SUM_W'(blue_q);
					sum_g_q <= sum_g_q + lrcs_pkg::SUM_W'(green_q);
					sum_r_q <= sum_r_q + lrcs_pkg::SUM_W'(red_q);
					count_q <= count_q + lrcs_pkg::CNT_W'(1);
				end
			end
			if (cmd.match_en)
				mask_q <= (l1_dist < color_threshold_q);
			if (cmd.div_store) begin
				case (cmd.div_ch)
					lrcs_pkg::CH_BLUE:  mean_b_q <= mean_val;
					lrcs_pkg::CH_GREEN: mean_g_q <= mean_val;
					default:            mean_r_q <= mean_val;
				endcase
			end
			if (cmd.mean_commit) begin
				sum_b_q <= '0;
				sum_g_q <= '0;
				sum_r_q <= '0;
				count_q <= '0;
				mv_q    <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			m_tdata_q <= {6'd0, mv_q, mean_r_q, mean_g_q, mean_b_q, mask_q};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign sts.eop      = eop_q && !op_q;
	assign sts.div_done = div_done;
	assign sts.out_free = !m_tvalid_q || m_tready;

endmodule

>>> hdl/lrcs_ctrl.sv
// Controller: sequences one word through the boundary test, match test and mean division.
`timescale 1ns / 1ps

module lrcs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tuser,
	output logic                 s_tready,
	output lrcs_pkg::lrcs_cmd_t  cmd,
	input  lrcs_pkg::lrcs_sts_t  sts
);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_MUL      = 4'd1;
	localparam logic [3:0] ST_EDGE     = 4'd2;
	localparam logic [3:0] ST_SPAN     = 4'd3;
	localparam logic [3:0] ST_TEST     = 4'd4;
	localparam logic [3:0] ST_MATCH    = 4'd5;
	localparam logic [3:0] ST_DIV_GO   = 4'd6;
	localparam logic [3:0] ST_DIV_WAIT = 4'd7;
	localparam logic [3:0] ST_COMMIT   = 4'd8;
	localparam logic [3:0] ST_EMIT     = 4'd9;

	logic [3:0] state_q, state_nx;
	logic [1:0] ch_q, ch_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= lrcs_pkg::CH_BLUE;
		end else begin
			state_q <= state_nx;
			ch_q    <= ch_nx;
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_nx = state_q;
		ch_nx    = ch_q;
		cmd      = '0;
		cmd.div_ch = ch_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.take = 1'b1;
					state_nx = s_tuser ? ST_MATCH : ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_nx   = ST_EDGE;
			end
			ST_EDGE: begin
				cmd.edge_en = 1'b1;
				state_nx    = ST_SPAN;
			end
			ST_SPAN: begin
				cmd.span_en = 1'b1;
				state_nx    = ST_TEST;
			end
			ST_TEST: begin
				cmd.test_en = 1'b1;
				ch_nx       = lrcs_pkg::CH_BLUE;
				state_nx    = sts.eop ? ST_DIV_GO : ST_EMIT;
			end
			ST_MATCH: begin
				cmd.match_en = 1'b1;
				state_nx     = ST_EMIT;
			end
			ST_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_nx      = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (sts.div_done) begin
					cmd.div_store = 1'b1;
					if (ch_q == lrcs_pkg::CH_RED) begin
						state_nx = ST_COMMIT;
					end else begin
						ch_nx    = ch_q + 2'd1;
						state_nx = ST_DIV_GO;
					end
				end
			end
			ST_COMMIT: begin
				cmd.mean_commit = 1'b1;
				state_nx        = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

endmodule

>>> tb/tb_lane_region_color_segmenter_unit.sv
// Self-checking testbench for the lane segmenter: directed table, random lane frames, predictor.
`timescale 1ns / 1ps

module tb_lane_region_color_segmenter_unit;
	import lrcs_pkg::*;

	localparam logic OP_REGION = 1'b0;
	localparam logic OP_MATCH  = 1'b1;
	// index outside the register map, must be ignored
	localparam logic [CIDX_W-1:0] REG_UNUSED = 3'd6;

	localparam int RANDOM_WORDS   = 1750;
	localparam int BACKLOG_CYCLES = 400;
	localparam int BACKLOG_AFTER  = 400;
	localparam int IDLE_GAP       = 8;
	localparam int END_SETTLE     = 150;

	typedef struct packed {
		logic             op;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [CH_W-1:0]  blue;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  red;
		logic             eop;
	} pixel_t;

	typedef struct packed {
		logic            in_mask;
		logic [CH_W-1:0] mean_blue;
		logic [CH_W-1:0] mean_green;
		logic [CH_W-1:0] mean_red;
		logic            mean_valid;
	} seg_t;

	typedef struct {
		int     phase;
		pixel_t pix;
		bit     typed;
		seg_t   want;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CIDX_W-1:0]      cfg_index;
	logic [CFG_W-1:0]       cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tuser;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	// predictor copy of registers and state
	int               lslope, loffset, rslope, roffset;
	logic [RW_W-1:0]  region_w;
	logic [THR_W-1:0] match_thr;
	logic [SUM_W-1:0] sum_b, sum_g, sum_r;
	logic [CNT_W-1:0] pix_cnt;
	logic [CH_W-1:0]  mean_b, mean_g, mean_r;

	seg_t     seg_results_q[$];
	dir_row_t dir_rows[$];

	int  n_errors = 0;
	int  n_accepted = 0;
	int  n_checked = 0;
	int  n_latched = 0;
	int  n_masked = 0;
	int  n_settings = 0;
	int  burst_left = 0;
	bit  backlog_done = 0;

	lane_region_color_segmenter_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// trapezoid span test for one pixel, 64-bit fixed point
	function automatic bit lane_span_hit(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
		longint w, r, xl, xr, start, len, stop;
		w = longint'(region_w);
		if (w > MAX_WIDTH)
			w = MAX_WIDTH;
		if (row >= MAX_HEIGHT)
			return 1'b0;
		r = longint'(row);
		xl = r * longint'(lslope) + longint'(loffset);
		if (xl < 0)
			xl = 0;
		xr = r * longint'(rslope) + longint'(roffset);
		if (xr > (w <<< FRAC_BITS))
			xr = w <<< FRAC_BITS;
		if (xr <= xl)
			return 1'b0;
		// round half up on both start and length
		start = (xl + HALF) >>> FRAC_BITS;
		len = (xr - xl + HALF) >>> FRAC_BITS;
		stop = start + len;
		if (stop > w)
			stop = w;
		return longint'(col) >= start && longint'(col) < stop;
	endfunction

	function automatic logic [CH_W-1:0] channel_mean(input logic [SUM_W-1:0] sum,
			input logic [CNT_W-1:0] cnt);
		longint m;
		if (cnt == 0)
			return '0;
		m = (longint'(sum) + longint'(cnt >> 1)) / longint'(cnt);
		return (m > MEAN_MAX) ? CH_W'(MEAN_MAX) : m[CH_W-1:0];
	endfunction

	function automatic int absdiff8(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
		return (a > b) ? int'(a - b) : int'(b - a);
	endfunction

	// advances accumulators / mean and returns the expected result word
	function automatic seg_t segment_pixel(input pixel_t p);
		seg_t res;
		int   l1_dist;
		res = '0;
		if (p.op == OP_REGION) begin
			if (lane_span_hit(p.row, p.col)) begin
				res.in_mask = 1'b1;
				sum_b = sum_b + SUM_W'(p.blue);
				sum_g = sum_g + SUM_W'(p.green);
				sum_r = sum_r + SUM_W'(p.red);
				pix_cnt = pix_cnt + 1'b1;
			end
			if (p.eop) begin
				mean_b = channel_mean(sum_b, pix_cnt);
				mean_g = channel_mean(sum_g, pix_cnt);
				mean_r = channel_mean(sum_r, pix_cnt);
				sum_b = '0;
				sum_g = '0;
				sum_r = '0;
				pix_cnt = '0;
				res.mean_valid = 1'b1;
			end
		end else begin
			l1_dist = absdiff8(p.blue, mean_b) + absdiff8(p.green, mean_g)
				+ absdiff8(p.red, mean_r);
			res.in_mask = (l1_dist < int'(match_thr));
		end
		res.mean_blue = mean_b;
		res.mean_green = mean_g;
		res.mean_red = mean_r;
		return res;
	endfunction

	function automatic logic [CH_W-1:0] jitter(input logic [CH_W-1:0] base, input int spread);
		int v;
		v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[CH_W-1:0];
	endfunction

	// boundary register values: the signed extremes, zero, random, or small values around zero
	function automatic logic [CFG_W-1:0] bound_value();
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3: return $urandom;
			default: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
		endcase
	endfunction

	// directed row; typed rows expect a zero mean
	function automatic void dir_add(input int phase, input logic op, input int row, input int col,
			input int b, input int g, input int r, input logic eop, input bit typed,
			input logic want_mask, input logic want_valid);
		dir_row_t d;
		d.phase = phase;
		d.pix = '{op: op, row: ROW_W'(row), col: COL_W'(col), blue: CH_W'(b), green: CH_W'(g),
			red: CH_W'(r), eop: eop};
		d.typed = typed;
		d.want = '{in_mask: want_mask, mean_blue: '0, mean_green: '0, mean_red: '0,
			mean_valid: want_valid};
		dir_rows.push_back(d);
	endfunction

	// config write; caller drops cfg_valid after the last one of a group
	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_LEFT_SLOPE:   lslope = int'(val);
			REG_LEFT_OFFSET:  loffset = int'(val);
			REG_RIGHT_SLOPE:  rslope = int'(val);
			REG_RIGHT_OFFSET: roffset = int'(val);
			REG_REGION_WIDTH: region_w = val[RW_W-1:0];
			REG_COLOR_THR:    match_thr = val[THR_W-1:0];
			default: ;
		endcase
	endtask

	// one pixel word, sent in bursts with random gaps
	task automatic send_word(input pixel_t p, input bit typed, input seg_t typed_res);
		seg_t res;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat (($urandom_range(0, 4) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3))
				@(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tuser <= p.op;
		s_tlast <= p.eop;
		s_tdata <= {2'b00, p.red, p.green, p.blue, p.col, p.row};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		n_accepted++;
		res = segment_pixel(p);
		seg_results_q.push_back(typed ? typed_res : res);
	endtask

	// stop sending and let every pending result come out
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (seg_results_q.size() != 0)
			@(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		seg_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (seg_results_q.size() == 0) begin
				$error("result word with no prediction pending: %h", m_tdata);
				n_errors++;
			end else begin
				want = seg_results_q.pop_front();
				check_field("in_mask", 8'(want.in_mask), 8'(m_tdata[0]));
				check_field("mean_blue", want.mean_blue, m_tdata[8:1]);
				check_field("mean_green", want.mean_green, m_tdata[16:9]);
				check_field("mean_red", want.mean_red, m_tdata[24:17]);
				check_field("mean_valid", 8'(want.mean_valid), 8'(m_tdata[25]));
				check_field("pad", 8'd0, 8'(m_tdata[31:26]));
				n_checked++;
				if (want.mean_valid)
					n_latched++;
				if (want.in_mask)
					n_masked++;
			end
		end
	end

	// output side: changing stall patterns, one long hold-off
	initial begin
		int ready_mode;
		int mode_left;
		ready_mode = 0;
		mode_left = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!backlog_done && n_accepted >= BACKLOG_AFTER) begin
				m_tready <= 1'b0;
				repeat (BACKLOG_CYCLES) @(posedge clk);
				backlog_done = 1;
			end
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			case (ready_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ((mode_left % 5) < 2);
			endcase
		end
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("tb_lane_region_color_segmenter_unit: errors");
		$finish;
	end

	// stimulus
	initial begin
		pixel_t            p;
		logic [CH_W-1:0]   base_b, base_g, base_r;
		logic [RW_W-1:0]   wval;
		logic [THR_W-1:0]  tval;
		logic [CFG_W-1:0]  junk;
		int                cur_phase, row_span, col_span, weff, n0, n1, spread, cfg_style;
		longint            fx_w, span, lo, ro, ls, rs;
		bit                noisy;

		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		s_tlast <= 1'b0;
		arst_n <= 1'b0;

		// predictor at reset defaults
		lslope = 0;
		loffset = 0;
		rslope = 0;
		roffset = 0;
		region_w = RW_W'(MAX_WIDTH);
		match_thr = THR_W'(50);
		sum_b = '0;
		sum_g = '0;
		sum_r = '0;
		pix_cnt = '0;
		mean_b = '0;
		mean_g = '0;
		mean_r = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: both edges at zero, so no pixel is inside; mean stays zero
		dir_add(0, OP_REGION, 0, 0, 0, 0, 0, 1'b0, 1, 1'b0, 1'b0);
		dir_add(0, OP_REGION, 2047, 2047, 255, 255, 255, 1'b0, 1, 1'b0, 1'b0);
		dir_add(0, OP_MATCH, 0, 0, 0, 0, 0, 1'b0, 1, 1'b1, 1'b0);
		dir_add(0, OP_REGION, 1023, 5, 12, 34, 56, 1'b1, 1, 1'b0, 1'b1);
		// distance just under and at the threshold
		dir_add(0, OP_MATCH, 3, 4, 16, 16, 17, 1'b0, 1, 1'b1, 1'b0);
		dir_add(0, OP_MATCH, 3, 4, 17, 17, 16, 1'b0, 1, 1'b0, 1'b0);
		// end mark in the match pass latches nothing
		dir_add(0, OP_MATCH, 2047, 2047, 255, 255, 255, 1'b1, 1, 1'b0, 1'b0);
		// full region, width above the maximum, threshold above any distance
		dir_add(1, OP_REGION, 0, 0, 255, 0, 128, 1'b0, 0, 1'b0, 1'b0);
		dir_add(1, OP_REGION, 2047, 2047, 0, 255, 1, 1'b0, 0, 1'b0, 1'b0);
		dir_add(1, OP_REGION, 100, 2047, 10, 20, 30, 1'b0, 0, 1'b0, 1'b0);
		dir_add(1, OP_REGION, 5, 1000, 255, 255, 255, 1'b1, 0, 1'b0, 1'b0);
		dir_add(1, OP_MATCH, 0, 0, 0, 0, 0, 1'b0, 0, 1'b0, 1'b0);
		dir_add(1, OP_MATCH, 9, 9, 255, 255, 255, 1'b1, 0, 1'b0, 1'b0);
		// zero width: empty pass; zero threshold never matches
		dir_add(2, OP_REGION, 0, 0, 200, 100, 50, 1'b1, 1, 1'b0, 1'b1);
		dir_add(2, OP_REGION, 2047, 0, 255, 255, 255, 1'b0, 1, 1'b0, 1'b0);
		dir_add(2, OP_MATCH, 0, 0, 0, 0, 0, 1'b0, 1, 1'b0, 1'b0);
		dir_add(2, OP_MATCH, 1, 1, 255, 255, 255, 1'b1, 1, 1'b0, 1'b0);
		// sloped edges with half-pixel rounding and the span end clamp at row 0
		dir_add(3, OP_REGION, 0, 0, 40, 50, 60, 1'b0, 0, 1'b0, 1'b0);
		dir_add(3, OP_REGION, 0, 1, 41, 51, 61, 1'b0, 0, 1'b0, 1'b0);
		dir_add(3, OP_REGION, 0, 15, 44, 52, 66, 1'b0, 0, 1'b0, 1'b0);
		dir_add(3, OP_REGION, 2, 1, 200, 200, 200, 1'b0, 0, 1'b0, 1'b0);
		dir_add(3, OP_REGION, 2, 15, 47, 49, 63, 1'b0, 0, 1'b0, 1'b0);
		dir_add(3, OP_REGION, 31, 8, 90, 90, 90, 1'b1, 0, 1'b0, 1'b0);
		dir_add(3, OP_MATCH, 7, 7, 0, 255, 0, 1'b0, 0, 1'b0, 1'b0);

		// directed table
		cur_phase = 0;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].phase != cur_phase) begin
				wait_idle();
				cur_phase = dir_rows[i].phase;
				n_settings++;
				case (cur_phase)
					1: begin
						write_reg(REG_LEFT_SLOPE, 32'h0);
						write_reg(REG_LEFT_OFFSET, 32'h8000_0000);
						write_reg(REG_RIGHT_SLOPE, 32'h0);
						write_reg(REG_RIGHT_OFFSET, 32'h7FFF_FFFF);
						write_reg(REG_REGION_WIDTH, 32'h0000_0FFF);
						write_reg(REG_COLOR_THR, 32'd766);
					end
					2: begin
						write_reg(REG_UNUSED, 32'hDEAD_BEEF);
						write_reg(REG_REGION_WIDTH, 32'hFFFF_F000);
						write_reg(REG_COLOR_THR, 32'h0);
					end
					default: begin
						write_reg(REG_LEFT_SLOPE, 32'h0000_8000);
						write_reg(REG_LEFT_OFFSET, 32'h0000_8000);
						write_reg(REG_RIGHT_SLOPE, 32'hFFFF_8000);
						write_reg(REG_RIGHT_OFFSET, 32'h0010_8000);
						write_reg(REG_REGION_WIDTH, 32'd16);
						write_reg(REG_COLOR_THR, 32'h3FF);
					end
				endcase
				cfg_valid <= 1'b0;
			end
			send_word(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].want);
		end

		// random lane frames, new register set per round
		while (n_accepted < dir_rows.size() + RANDOM_WORDS) begin
			wait_idle();
			n_settings++;
			cfg_style = $urandom_range(0, 3);
			case ($urandom_range(0, 3))
				0: row_span = 15;
				1: row_span = 63;
				2: row_span = 255;
				default: row_span = 2047;
			endcase
			if (cfg_style == 3) begin
				case ($urandom_range(0, 4))
					0: wval = '0;
					1: wval = RW_W'(1);
					2: wval = RW_W'(MAX_WIDTH);
					3: wval = '1;
					default: wval = RW_W'($urandom_range(0, 4095));
				endcase
			end else begin
				wval = ($urandom_range(0, 7) == 0) ? RW_W'($urandom_range(MAX_WIDTH + 1, 4095)) :
					RW_W'($urandom_range(16, MAX_WIDTH));
			end
			weff = (int'(wval) > MAX_WIDTH) ? MAX_WIDTH : int'(wval);
			col_span = (weff + 4 > 2047) ? 2047 : weff + 4;
			case ($urandom_range(0, 5))
				0: tval = '0;
				1: tval = THR_W'(1);
				2: tval = THR_W'(766);
				3: tval = '1;
				4: tval = THR_W'($urandom_range(0, 200));
				default: tval = THR_W'($urandom_range(0, 766));
			endcase
			junk = ($urandom_range(0, 3) == 0) ? $urandom : '0;

			if (cfg_style == 3) begin
				write_reg(REG_LEFT_SLOPE, bound_value());
				write_reg(REG_LEFT_OFFSET, bound_value());
				write_reg(REG_RIGHT_SLOPE, bound_value());
				write_reg(REG_RIGHT_OFFSET, bound_value());
			end else begin
				// lane shaped: edges move at most about one region width over the rows used
				fx_w = longint'(weff) <<< FRAC_BITS;
				span = fx_w / (row_span + 1);
				lo = longint'($urandom_range(0, 32'(fx_w / 2))) - fx_w / 8;
				ro = lo + longint'($urandom_range(0, 32'(fx_w)));
				ls = longint'($urandom_range(0, 32'(2 * span))) - span;
				rs = longint'($urandom_range(0, 32'(2 * span))) - span;
				write_reg(REG_LEFT_SLOPE, 32'(ls));
				write_reg(REG_LEFT_OFFSET, 32'(lo));
				write_reg(REG_RIGHT_SLOPE, 32'(rs));
				write_reg(REG_RIGHT_OFFSET, 32'(ro));
			end
			write_reg(REG_REGION_WIDTH, {junk[CFG_W-1:RW_W], wval});
			write_reg(REG_COLOR_THR, {junk[CFG_W-1:THR_W], tval});
			cfg_valid <= 1'b0;

			repeat ($urandom_range(2, 5)) begin
				// region pass around a base color, with stray match words and early ends
				base_b = CH_W'($urandom);
				base_g = CH_W'($urandom);
				base_r = CH_W'($urandom);
				noisy = ($urandom_range(0, 3) == 0);
				spread = $urandom_range(0, 40);
				n0 = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(4, 60);
				for (int k = 0; k < n0; k++) begin
					p.op = ($urandom_range(0, 19) == 0) ? OP_MATCH : OP_REGION;
					p.row = ROW_W'($urandom_range(0, row_span));
					p.col = ($urandom_range(0, 3) == 0) ? COL_W'($urandom_range(0, 2047)) :
						COL_W'($urandom_range(0, col_span));
					p.blue = noisy ? CH_W'($urandom) : jitter(base_b, spread);
					p.green = noisy ? CH_W'($urandom) : jitter(base_g, spread);
					p.red = noisy ? CH_W'($urandom) : jitter(base_r, spread);
					p.eop = (k == n0 - 1) || ($urandom_range(0, 29) == 0);
					send_word(p, 1'b0, '0);
				end

				// match pass, mostly near the latched mean
				spread = $urandom_range(0, 300);
				n1 = $urandom_range(1, 40);
				for (int k = 0; k < n1; k++) begin
					p.op = ($urandom_range(0, 19) == 0) ? OP_REGION : OP_MATCH;
					p.row = ROW_W'($urandom);
					p.col = COL_W'($urandom);
					if ($urandom_range(0, 4) < 3) begin
						p.blue = jitter(mean_b, spread / 3);
						p.green = jitter(mean_g, spread / 3);
						p.red = jitter(mean_r, spread / 3);
					end else begin
						p.blue = CH_W'($urandom);
						p.green = CH_W'($urandom);
						p.red = CH_W'($urandom);
					end
					p.eop = (k == n1 - 1) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 29) == 0);
					send_word(p, 1'b0, '0);
				end
			end
		end

		// drain and settle
		wait_idle();
		repeat (END_SETTLE) @(posedge clk);

		$display("Sent %0d pixel words (%0d directed) under %0d register settings.",
			n_accepted, dir_rows.size(), n_settings);
		$display("Checked %0d results: %0d mean latches, %0d mask hits, %0d-cycle output hold-off.",
			n_checked, n_latched, n_masked, BACKLOG_CYCLES);
		if (n_errors == 0)
			$display("tb_lane_region_color_segmenter_unit: clean");
		else
			$display("tb_lane_region_color_segmenter_unit: errors");
		$finish;
	end

endmodule
